// ===== rtl/dfs_pkg.sv =====
// Shared types and constants for the depth-first topological sort block.
package dfs_pkg;
    localparam int MaxVertices = 64;
    localparam int MaxEdges    = 256;
    localparam int VW = $clog2(MaxVertices);
    localparam int EW = $clog2(MaxEdges);
    localparam int EC = $clog2(MaxEdges + 1);
    localparam int CW = 7;

    typedef enum logic {CMD_ADD = 1'b0, CMD_SORT = 1'b1} cmd_t;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_BAD  = 2'd2;

    typedef struct packed {
        logic          command;
        logic [VW-1:0] from_vertex;
        logic [VW-1:0] to_vertex;
    } req_t;

    typedef struct packed {
        logic [1:0]    status;
        logic [VW-1:0] order_vertex;
        logic          last;
    } rsp_t;
endpackage

// ===== rtl/dfs_stream_if.sv =====
// Valid/ready channel carrying one payload.
interface dfs_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/dfs_ram.sv =====
// Generic single-port-write, one-read synchronous RAM.
module dfs_ram #(
    parameter int Depth = 64,
    parameter int Width = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/dfs_topological_sort_top.sv =====
// Top level: edge store, depth-first walk sequencer and order output.
// Add: checks both vertices and the table space, then links the edge in; a rejected edge
// answers without a write. Sort: checks each root, enters unvisited vertices, walks their edges,
// finishes each vertex (reloading the stack top unless it was a root), then emits the order.
// One request at a time; the next is taken once its last result has left.
// Reset clears edge count, has_edges and visited flags, vertex count 64; RAMs keep data.
module dfs_topological_sort_top
    import dfs_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [CW-1:0] cfg_wdata,
    dfs_stream_if.sink    req,
    dfs_stream_if.source  rsp
);
    typedef enum logic [3:0] {
        S_IDLE, S_ADD_RD, S_ADD_WR, S_NEXT_ROOT, S_ENTER_RD, S_TOP_RD, S_EDGE_RD,
        S_EDGE_USE, S_EMIT_RD, S_EMIT, S_OUT
    } state_t;

    state_t        state_reg;
    logic [CW-1:0] vcount_reg;
    logic [EC-1:0] used_reg;
    logic [MaxVertices-1:0] has_reg, vis_reg;
    logic [VW:0]   top_reg, fin_reg, root_reg;
    logic [VW-1:0] x_reg, y_reg, v_reg;
    logic [EW-1:0] cur_reg;
    logic          pend_reg, emit_reg;
    rsp_t          out_reg;

    // Walk stack entry: vertex, current edge, pending.
    localparam int SW = VW + EW + 1;
    logic          ws_we;  logic [VW-1:0] ws_wa, ws_ra; logic [SW-1:0] ws_wd, ws_rd;
    logic          fs_we;  logic [VW-1:0] fs_wa, fs_ra; logic [VW-1:0] fs_wd, fs_rd;
    logic          et_we;  logic [EW-1:0] et_wa, et_ra; logic [VW-1:0] et_rd;
    logic          el_we;  logic [EW-1:0] el_wa;        logic [EW-1:0] el_rd;
    logic          ch_we;  logic [VW-1:0] ch_wa, ch_ra; logic [EW-1:0] ch_wd, ch_rd;
    logic          ct_we;  logic [VW-1:0] ct_wa, ct_ra; logic [EW-1:0] ct_rd;

    dfs_ram #(.Depth(MaxVertices), .Width(SW)) u_walk (.clk, .we(ws_we), .waddr(ws_wa),
        .wdata(ws_wd), .raddr(ws_ra), .rdata(ws_rd));
    dfs_ram #(.Depth(MaxVertices), .Width(VW)) u_fin (.clk, .we(fs_we), .waddr(fs_wa),
        .wdata(fs_wd), .raddr(fs_ra), .rdata(fs_rd));
    dfs_ram #(.Depth(MaxEdges), .Width(VW)) u_tgt (.clk, .we(et_we), .waddr(et_wa),
        .wdata(y_reg), .raddr(et_ra), .rdata(et_rd));
    dfs_ram #(.Depth(MaxEdges), .Width(EW)) u_link (.clk, .we(el_we), .waddr(el_wa),
        .wdata(used_reg[EW-1:0]), .raddr(cur_reg), .rdata(el_rd));
    dfs_ram #(.Depth(MaxVertices), .Width(EW)) u_head (.clk, .we(ch_we), .waddr(ch_wa),
        .wdata(ch_wd), .raddr(ch_ra), .rdata(ch_rd));
    dfs_ram #(.Depth(MaxVertices), .Width(EW)) u_tail (.clk, .we(ct_we), .waddr(ct_wa),
        .wdata(used_reg[EW-1:0]), .raddr(ct_ra), .rdata(ct_rd));

    logic [VW:0] n_eff;
    always_comb
    begin
        if (vcount_reg == '0)
            n_eff = (VW+1)'(1);
        else if (vcount_reg > CW'(MaxVertices))
            n_eff = (VW+1)'(MaxVertices);
        else
            n_eff = vcount_reg[VW:0];
    end

    assign req.ready   = (state_reg == S_IDLE) && !emit_reg;
    assign rsp.valid   = emit_reg;
    assign rsp.payload = out_reg;

    logic          tv_ok;
    logic [VW-1:0] top_idx;
    assign top_idx = top_reg[VW-1:0] - VW'(1);
    assign tv_ok   = ({1'b0, et_rd} < n_eff) && !vis_reg[et_rd]
                     && (top_reg < (VW+1)'(MaxVertices));

    // Memory control
    always_comb
    begin
        ws_we = 1'b0; ws_wa = top_idx; ws_wd = '0; ws_ra = top_idx;
        fs_we = 1'b0; fs_wa = fin_reg[VW-1:0]; fs_wd = v_reg;
        fs_ra = fin_reg[VW-1:0] - VW'(1);
        et_we = 1'b0; et_wa = used_reg[EW-1:0]; et_ra = cur_reg;
        el_we = 1'b0; el_wa = ct_rd;
        ch_we = 1'b0; ch_wa = x_reg; ch_wd = used_reg[EW-1:0]; ch_ra = v_reg;
        ct_we = 1'b0; ct_wa = x_reg; ct_ra = x_reg;
        case (state_reg)
            S_ADD_WR:
            begin
                et_we = 1'b1; ct_we = 1'b1;
                ch_we = !has_reg[x_reg];
                el_we = has_reg[x_reg];
            end
            S_ENTER_RD:
            begin
                ct_ra = v_reg;
            end
            S_TOP_RD:
            begin
                // push freshly entered vertex
                ws_we = 1'b1; ws_wa = top_reg[VW-1:0];
                ws_wd = {v_reg, has_reg[v_reg] ? ch_rd : EW'(0), has_reg[v_reg]};
            end
            S_EDGE_RD:
            begin
                ct_ra = v_reg;
                if (!pend_reg)
                begin
                    fs_we = (fin_reg < (VW+1)'(MaxVertices));
                end
            end
            S_EDGE_USE:
            begin
                ws_we = 1'b1;
                ws_wd = {v_reg, (cur_reg == ct_rd) ? cur_reg : el_rd, cur_reg != ct_rd};
                ch_ra = et_rd;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            vcount_reg <= CW'(MaxVertices);
            used_reg   <= '0;
            has_reg    <= '0;
            vis_reg    <= '0;
            emit_reg   <= 1'b0;
            top_reg    <= '0;
            fin_reg    <= '0;
            root_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
                vcount_reg <= cfg_wdata;
            if (emit_reg && rsp.ready)
                emit_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid && req.ready)
                    begin
                        x_reg <= req.payload.from_vertex;
                        y_reg <= req.payload.to_vertex;
                        if (req.payload.command == CMD_SORT)
                        begin
                            vis_reg <= '0; top_reg <= '0; fin_reg <= '0;
                            root_reg <= '0;
                            state_reg <= S_NEXT_ROOT;
                        end
                        else
                            state_reg <= S_ADD_RD;
                    end
                end
                S_ADD_RD:
                begin
                    out_reg.order_vertex <= '0;
                    out_reg.last <= 1'b1;
                    if ({1'b0, x_reg} >= n_eff || {1'b0, y_reg} >= n_eff)
                    begin
                        out_reg.status <= STAT_BAD; emit_reg <= 1'b1; state_reg <= S_IDLE;
                    end
                    else if (used_reg >= EC'(MaxEdges))
                    begin
                        out_reg.status <= STAT_FULL; emit_reg <= 1'b1; state_reg <= S_IDLE;
                    end
                    else
                        state_reg <= S_ADD_WR;  // tail read lands now
                end
                S_ADD_WR:
                begin
                    has_reg[x_reg] <= 1'b1;
                    used_reg <= used_reg + EC'(1);
                    out_reg.status <= STAT_OK;
                    emit_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_NEXT_ROOT:
                begin
                    if (root_reg >= n_eff)
                        state_reg <= S_EMIT_RD;
                    else if (vis_reg[root_reg[VW-1:0]])
                        root_reg <= root_reg + (VW+1)'(1);
                    else
                    begin
                        v_reg <= root_reg[VW-1:0];
                        root_reg <= root_reg + (VW+1)'(1);
                        state_reg <= S_ENTER_RD;
                    end
                end
                S_ENTER_RD:
                begin
                    // head read issued
                    vis_reg[v_reg] <= 1'b1;
                    state_reg <= S_TOP_RD;
                end
                S_TOP_RD:
                begin
                    top_reg <= top_reg + (VW+1)'(1);
                    v_reg <= v_reg;
                    state_reg <= S_EDGE_RD;
                    // stack top is the pushed entry; load it directly
                    cur_reg <= has_reg[v_reg] ? ch_rd : EW'(0);
                    pend_reg <= has_reg[v_reg];
                end
                S_EDGE_RD:
                begin
                    if (!pend_reg)
                    begin
                        if (fin_reg < (VW+1)'(MaxVertices))
                            fin_reg <= fin_reg + (VW+1)'(1);
                        top_reg <= top_reg - (VW+1)'(1);
                        if (top_reg == (VW+1)'(1))
                            state_reg <= S_NEXT_ROOT;
                        else
                            state_reg <= S_OUT;  // reload next top
                    end
                    else
                        state_reg <= S_EDGE_USE;
                end
                S_EDGE_USE:
                begin
                    cur_reg <= (cur_reg == ct_rd) ? cur_reg : el_rd;
                    pend_reg <= (cur_reg != ct_rd);
                    if (tv_ok)
                    begin
                        v_reg <= et_rd;
                        state_reg <= S_ENTER_RD;
                    end
                    else
                        state_reg <= S_EDGE_RD;
                end
                S_OUT:
                begin
                    // walk stack read lands next cycle; reuse S_EMIT as load step
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (fin_reg == '0 || top_reg != '0)
                    begin
                        // stack reload path
                        {v_reg, cur_reg, pend_reg} <= ws_rd;
                        state_reg <= S_EDGE_RD;
                    end
                    else if (!emit_reg)
                    begin
                        out_reg.status <= STAT_OK;
                        out_reg.order_vertex <= fs_rd;
                        out_reg.last <= (fin_reg == (VW+1)'(1));
                        emit_reg <= 1'b1;
                        fin_reg <= fin_reg - (VW+1)'(1);
                        state_reg <= (fin_reg == (VW+1)'(1)) ? S_IDLE : S_EMIT_RD;
                    end
                end
                S_EMIT_RD:
                begin
                    top_reg <= '0;
                    state_reg <= S_EMIT;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the depth-first topological sort block.
module tb_top;
    import dfs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 3_000_000;
    localparam int HoldCycles = 400;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          cfg_we;
    logic [CW-1:0] cfg_wdata;

    dfs_stream_if #(.payload_t(req_t)) req_if ();
    dfs_stream_if #(.payload_t(rsp_t)) rsp_if ();

    dfs_topological_sort_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_if),
        .rsp       (rsp_if)
    );

    always #1 clk = ~clk;

    // graph mirror kept by the predictor
    logic [VW-1:0] edge_dst [MaxEdges];
    logic [EW-1:0] edge_next [MaxEdges];
    logic [EW-1:0] head_edge [MaxVertices];
    logic [EW-1:0] tail_edge [MaxVertices];
    bit            has_edge [MaxVertices];
    int            edge_cnt = 0;
    logic [CW-1:0] vcount_reg;

    req_t pending_reqs [$];
    rsp_t expected_rsps [$];

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_req;
    bit  hold_done;
    int  hold_cnt;
    int  errors = 0;
    int  cycles = 0;
    int  n_adds, n_sorts, n_full, n_bad, n_results;

    function automatic int live_vertices();
        if (vcount_reg == 0) return 1;
        if (vcount_reg > MaxVertices) return MaxVertices;
        return int'(vcount_reg);
    endfunction

    // Walk from vertex 0 upward and queue the reverse finishing order.
    function automatic void predict_order();
        bit            seen [MaxVertices];
        logic [VW-1:0] wv [MaxVertices];
        logic [EW-1:0] wcur [MaxVertices];
        bit            wpend [MaxVertices];
        logic [VW-1:0] fin_v [MaxVertices];
        int            n, fin, top, e, t, i;
        rsp_t          r;
        n = live_vertices();
        fin = 0;
        top = 0;
        for (int v = 0; v < MaxVertices; v++) seen[VW'(v)] = 1'b0;
        for (int s = 0; s < n; s++)
        begin
            if (seen[VW'(s)]) continue;
            seen[VW'(s)] = 1'b1;
            wv[VW'(top)] = VW'(s);
            wpend[VW'(top)] = has_edge[VW'(s)];
            wcur[VW'(top)] = head_edge[VW'(s)];
            top++;
            while (top > 0)
            begin
                i = top - 1;
                if (wpend[VW'(i)])
                begin
                    e = wcur[VW'(i)];
                    if (e == tail_edge[wv[VW'(i)]]) wpend[VW'(i)] = 1'b0;
                    else wcur[VW'(i)] = edge_next[EW'(e)];
                    t = edge_dst[EW'(e)];
                    if (t < n && !seen[VW'(t)] && top < MaxVertices)
                    begin
                        seen[VW'(t)] = 1'b1;
                        wv[VW'(top)] = VW'(t);
                        wpend[VW'(top)] = has_edge[VW'(t)];
                        wcur[VW'(top)] = head_edge[VW'(t)];
                        top++;
                    end
                end
                else
                begin
                    if (fin < MaxVertices)
                    begin
                        fin_v[VW'(fin)] = wv[VW'(i)];
                        fin++;
                    end
                    top--;
                end
            end
        end
        for (int k = 0; k < fin; k++)
        begin
            r.status = STAT_OK;
            r.order_vertex = fin_v[VW'(fin - 1 - k)];
            r.last = (k + 1 == fin);
            expected_rsps = {expected_rsps, r};
        end
    endfunction

    function automatic void predict_request(req_t q);
        rsp_t r;
        int   n;
        if (q.command == CMD_SORT)
        begin
            n_sorts++;
            predict_order();
            return;
        end
        n_adds++;
        n = live_vertices();
        if (q.from_vertex >= n || q.to_vertex >= n)
        begin
            r.status = STAT_BAD;
            n_bad++;
        end
        else if (edge_cnt >= MaxEdges)
        begin
            r.status = STAT_FULL;
            n_full++;
        end
        else
        begin
            edge_dst[EW'(edge_cnt)] = q.to_vertex;
            if (has_edge[q.from_vertex]) edge_next[tail_edge[q.from_vertex]] = EW'(edge_cnt);
            else head_edge[q.from_vertex] = EW'(edge_cnt);
            tail_edge[q.from_vertex] = EW'(edge_cnt);
            has_edge[q.from_vertex] = 1'b1;
            edge_cnt++;
            r.status = STAT_OK;
        end
        r.order_vertex = '0;
        r.last = 1'b1;
        expected_rsps = {expected_rsps, r};
    endfunction

    // Driver: offer the next request; predict it as it goes out, order is kept.
    always @(posedge clk or negedge rst_n)
    begin
        req_t q;
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
        end
        else if (!req_if.valid || req_if.ready)
        begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                q = pending_reqs.pop_front();
                predict_request(q);
                req_if.payload <= q;
                req_if.valid <= 1'b1;
            end
            else
            begin
                req_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cnt <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            if (hold_cnt == HoldCycles) hold_done <= 1'b1;
            else hold_cnt <= hold_cnt + 1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) rsp_if.ready <= 1'b0;
        else rsp_if.ready <= !(hold_req && !hold_done) && ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: compare every result with the oldest expectation.
    always @(posedge clk)
    begin
        rsp_t x;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            n_results++;
            if (expected_rsps.size() == 0)
            begin
                $error("unexpected result: status %0d vertex %0d last %0d",
                       rsp_if.payload.status, rsp_if.payload.order_vertex,
                       rsp_if.payload.last);
                errors++;
            end
            else
            begin
                x = expected_rsps.pop_front();
                if (rsp_if.payload.status !== x.status)
                begin
                    $error("status: expected %0d, got %0d", x.status, rsp_if.payload.status);
                    errors++;
                end
                if (rsp_if.payload.order_vertex !== x.order_vertex)
                begin
                    $error("order_vertex: expected %0d, got %0d",
                           x.order_vertex, rsp_if.payload.order_vertex);
                    errors++;
                end
                if (rsp_if.payload.last !== x.last)
                begin
                    $error("last: expected %0d, got %0d", x.last, rsp_if.payload.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_rsps.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_add(int from_v, int to_v);
        req_t q;
        q.command = CMD_ADD;
        q.from_vertex = VW'(from_v);
        q.to_vertex = VW'(to_v);
        pending_reqs = {pending_reqs, q};
    endtask

    task automatic send_sort();
        req_t q;
        q.command = CMD_SORT;
        q.from_vertex = VW'($urandom_range(63));
        q.to_vertex = VW'($urandom_range(63));
        pending_reqs = {pending_reqs, q};
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || req_if.valid || expected_rsps.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_vcount(int v);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= CW'(v);
        @(posedge clk);
        cfg_we <= 1'b0;
        vcount_reg = CW'(v);
    endtask

    // Mostly in-range edges with sorts between them; some out-of-range noise.
    task automatic send_mix(int count);
        int n;
        n = live_vertices();
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 12) send_sort();
            else if ($urandom_range(99) < 15) send_add($urandom_range(63), $urandom_range(63));
            else send_add($urandom_range(n - 1), $urandom_range(n - 1));
        end
        send_sort();
    endtask

    initial
    begin
        int idle_modes [4][2];
        idle_modes = '{'{0, 0}, '{52, 0}, '{0, 52}, '{20, 20}};
        cfg_we = 1'b0;
        cfg_wdata = '0;
        vcount_reg = 7'd64;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty graph at reset size, then a small graph with bad vertices
        send_sort();
        write_vcount(4);
        send_add(5, 1);
        send_add(1, 63);
        send_add(0, 1);
        send_add(1, 2);
        send_add(0, 2);
        send_add(3, 0);
        send_add(2, 2);
        send_sort();
        // stale edges: 0->2 and 1->2 now lead past the count
        write_vcount(2);
        send_sort();
        write_vcount(0);
        send_add(0, 0);
        send_add(1, 0);
        send_sort();
        write_vcount(127);
        send_add(63, 62);
        send_add(62, 0);
        send_sort();
        write_vcount(1);
        send_sort();

        foreach (idle_modes[m])
        begin
            write_vcount($urandom_range(1, 64));
            send_idle_pct = idle_modes[m][0];
            recv_idle_pct = idle_modes[m][1];
            send_mix(25);
            write_vcount(m == 2 ? 64 : $urandom_range(3, 12));
            send_mix(20);
        end

        // fill the edge table behind a long receiver hold-off
        write_vcount(64);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        while (edge_cnt + pending_reqs.size() < MaxEdges + 6)
            send_add($urandom_range(63), $urandom_range(63));
        send_sort();
        write_vcount(9);
        send_idle_pct = 20;
        recv_idle_pct = 20;
        send_mix(15);
        write_vcount(127);
        send_mix(6);
        wait_idle();

        $display("covered %0d adds (%0d bad vertex, %0d table full) and %0d sorts,",
                 n_adds, n_bad, n_full, n_sorts);
        $display("%0d results checked over %0d cycles", n_results, cycles);
        if (errors == 0 && expected_rsps.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
